### sv/murmur3_32_hash_core_assert.svh
// Assertion macros shared by the hash core modules.
`ifndef MURMUR3_32_HASH_CORE_ASSERT_SVH
`define MURMUR3_32_HASH_CORE_ASSERT_SVH

// Clocked check, quiet while reset is applied.
`define M3H_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define M3H_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/m3h_pkg.sv
// Package: constants, types and helper functions of the MurmurHash3 core.
`timescale 1ns / 1ps
`default_nettype none

package m3h_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned NB_W    = 3;

  localparam logic [WORD_W-1:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] MIX_C2 = 32'h1b873593;
  localparam int unsigned       MIX_R1 = 15;
  localparam int unsigned       FOLD_R2 = 13;
  localparam logic [WORD_W-1:0] FOLD_N = 32'he6546b64;
  localparam logic [WORD_W-1:0] FIN_C1 = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] FIN_C2 = 32'hc2b2ae35;

  localparam logic [NB_W-1:0] NB_FULL = 3'd4;

  // Queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [WORD_W-1:0] k;     // mixed word (zero for an empty item)
    logic [NB_W-1:0]   nb;    // valid bytes, clamped to 0..4
    logic              last;  // item closes the key
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_FIN1,
    BK_FIN2
  } back_state_e;

  function automatic logic [WORD_W-1:0] rotl13(input logic [WORD_W-1:0] x);
    rotl13 = {x[WORD_W-1-FOLD_R2:0], x[WORD_W-1:WORD_W-FOLD_R2]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl15(input logic [WORD_W-1:0] x);
    rotl15 = {x[WORD_W-1-MIX_R1:0], x[WORD_W-1:WORD_W-MIX_R1]};
  endfunction

endpackage

`default_nettype wire

### sv/m3h_ifs.sv
// Handshake interfaces for key items and hash results.
`timescale 1ns / 1ps
`default_nettype none

interface m3h_key_if
  import m3h_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] key_word;
  logic [NB_W-1:0]   word_bytes;
  logic              end_of_key;

  modport source (output valid, key_word, word_bytes, end_of_key, input ready);
  modport sink   (input valid, key_word, word_bytes, end_of_key, output ready);
endinterface

interface m3h_hash_if
  import m3h_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

### sv/m3h_front.sv
// Front end: takes key items, clamps and masks them, runs the word mix.
`timescale 1ns / 1ps
`default_nettype none

module m3h_front
  import m3h_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  m3h_key_if.sink        key_i,
  input  wire q_status_t q_status_i,
  output logic           push_o,
  output q_entry_t       entry_o
);

  logic              s1_valid_q, s1_valid_d;
  logic [WORD_W-1:0] s1_k1_q, s1_k1_d;
  logic [NB_W-1:0]   s1_nb_q, s1_nb_d;
  logic              s1_last_q, s1_last_d;

  logic              take;
  logic [WORD_W-1:0] masked;

  assign push_o      = s1_valid_q && !q_status_i.full;
  assign key_i.ready = !s1_valid_q || !q_status_i.full;
  assign take        = key_i.valid && key_i.ready;

  // Clamp the byte count; anything short ends the key.
  always_comb begin
    s1_nb_d   = (key_i.word_bytes > NB_FULL) ? NB_FULL : key_i.word_bytes;
    s1_last_d = key_i.end_of_key || (s1_nb_d != NB_FULL);
    case (s1_nb_d)
      3'd0:    masked = '0;
      3'd1:    masked = {24'd0, key_i.key_word[7:0]};
      3'd2:    masked = {16'd0, key_i.key_word[15:0]};
      3'd3:    masked = {8'd0, key_i.key_word[23:0]};
      default: masked = key_i.key_word;
    endcase
    s1_k1_d    = masked * MIX_C1;
    s1_valid_d = take || (s1_valid_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_k1_q   <= s1_k1_d;
      s1_nb_q   <= s1_nb_d;
      s1_last_q <= s1_last_d;
    end
  end

  // Second half of the mix feeds the queue directly.
  always_comb begin
    entry_o.k    = rotl15(s1_k1_q) * MIX_C2;
    entry_o.nb   = s1_nb_q;
    entry_o.last = s1_last_q;
  end

endmodule

`default_nettype wire

### sv/m3h_fifo.sv
// Short queue of mixed words between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_32_hash_core_assert.svh"

module m3h_fifo
  import m3h_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t entry_i,
  input  wire logic     pop_i,
  output q_entry_t      head_o,
  output q_status_t     status_o
);

  q_entry_t        mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  `M3H_ASSERT(a_no_push_full, !(push_i && status_o.full), "push into full queue")
  `M3H_ASSERT(a_no_pop_empty, !(pop_i && status_o.empty), "pop from empty queue")

endmodule

`default_nettype wire

### sv/m3h_back.sv
// Back end: folds mixed words into the running hash and finalizes keys.
`timescale 1ns / 1ps
`default_nettype none
`include "murmur3_32_hash_core_assert.svh"

module m3h_back
  import m3h_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [WORD_W-1:0] cfg_wdata_i,
  input  wire q_entry_t          head_i,
  input  wire q_status_t         q_status_i,
  output logic                   pop_o,
  m3h_hash_if.source             hash_o
);

  back_state_e state_q, state_d;

  logic [WORD_W-1:0] seed_q;
  logic [WORD_W-1:0] hash_q, hash_d;
  logic [WORD_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0] fin_q, fin_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_data_q, out_data_d;

  logic              can_load;
  logic              load_out;
  logic [WORD_W-1:0] mixed, rot, folded, cnt_new, fx1, fx2;

  assign can_load = !out_valid_q || hash_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_RUN: begin
        if (!q_status_i.empty && head_i.last) begin
          state_d = BK_FIN1;
        end
      end
      BK_FIN1: state_d = BK_FIN2;
      BK_FIN2: begin
        if (can_load) begin
          state_d = BK_RUN;
        end
      end
      default: state_d = BK_RUN;
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_RUN:  pop_o = !q_status_i.empty;
      BK_FIN1: ;
      BK_FIN2: load_out = can_load;
      default: ;
    endcase
  end

  // Datapath.
  always_comb begin
    mixed   = hash_q ^ head_i.k;
    rot     = rotl13(mixed);
    folded  = (head_i.nb == NB_FULL) ? ((rot << 2) + rot + FOLD_N) : mixed;
    cnt_new = cnt_q + {{(WORD_W-NB_W){1'b0}}, head_i.nb};
    fx1     = fin_q ^ (fin_q >> 16);
    fx2     = (fin_q ^ (fin_q >> 13)) * FIN_C2;

    hash_d = hash_q;
    cnt_d  = cnt_q;
    fin_d  = fin_q;
    if (pop_o) begin
      if (head_i.last) begin
        fin_d  = folded ^ cnt_new;
        hash_d = seed_q;
        cnt_d  = '0;
      end else begin
        hash_d = folded;
        cnt_d  = cnt_new;
      end
    end else if (state_q == BK_FIN1) begin
      fin_d = fx1 * FIN_C1;
    end
    if (cfg_we_i && (cnt_q == '0)) begin
      hash_d = cfg_wdata_i;
    end

    out_data_d  = fx2 ^ (fx2 >> 16);
    out_valid_d = load_out || (out_valid_q && !hash_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_RUN;
      seed_q      <= '0;
      hash_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  assign hash_o.valid      = out_valid_q;
  assign hash_o.hash_value = out_data_q;

  `M3H_ASSERT(a_pop_only_run, pop_o |-> (state_q == BK_RUN), "pop outside run state")
  `M3H_ASSERT(a_fin2_holds, (state_q == BK_FIN2 && !can_load) |=> (state_q == BK_FIN2), "result dropped while output busy")

endmodule

`default_nettype wire

### sv/murmur3_32_hash_core.sv
// Top level of the streaming MurmurHash3 x86_32 core.
// A final item passes the mix register, queue write, fold, finalize
//   multiply and multiply into the result register before hash_o.valid
//   rises. One word item per cycle is taken while the queue is not full;
//   a final item holds the back end for the fold and both finalize multiplies.
// Reset (rst_ni low, async): seed, running hash and byte count go to 0,
//   queue and result register empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module murmur3_32_hash_core
  import m3h_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [WORD_W-1:0] cfg_wdata_i,
  m3h_key_if.sink                key_i,
  m3h_hash_if.source             hash_o
);

  // Front to queue.
  logic      push;
  q_entry_t  push_entry;
  // Queue to back.
  q_entry_t  head;
  q_status_t q_status;
  logic      pop;

  // Front: clamp the byte count, mask unused bytes, mix the word in two
  // multiply stages. It stalls only on a full queue.
  m3h_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Two-entry queue lets the front keep taking words while the back end
  // is busy finishing a key or waiting on the result channel.
  m3h_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Back: fold into running hash, count bytes, finalize, hold seed.
  m3h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .hash_o      (hash_o)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the streaming MurmurHash3 x86_32 hash core.
`timescale 1ns / 1ps

module testbench;
  import m3h_pkg::*;

  // Run sizes and limits
  localparam int unsigned RANDOM_ITEMS    = 1150;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned SETTLE_CYCLES   = 12;      // margin for the core to settle after the last hash
  localparam int unsigned HOLD_OFF_CYCLES = 300;     // long result stall, fills the core
  localparam int unsigned CYCLE_LIMIT     = 300_000;

  localparam logic [NB_W-1:0] FULL_WORD = 3'd4;

  // Receiver stall patterns
  typedef enum int unsigned {
    SINK_ALWAYS,
    SINK_BUSY,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_e;

  // ---------------------------------------------------------------------------
  // Hash predictor and store of expected hashes.
  // ---------------------------------------------------------------------------
  class hash_scoreboard;
    // Algorithm constants, kept apart from the package on purpose
    localparam logic [31:0] K_MUL1 = 32'hcc9e2d51;
    localparam logic [31:0] K_MUL2 = 32'h1b873593;
    localparam logic [31:0] H_MUL  = 32'd5;
    localparam logic [31:0] H_ADD  = 32'he6546b64;
    localparam logic [31:0] F_MUL1 = 32'h85ebca6b;
    localparam logic [31:0] F_MUL2 = 32'hc2b2ae35;

    logic [WORD_W-1:0] seed_word;
    logic [WORD_W-1:0] acc_hash;
    logic [WORD_W-1:0] key_len;
    logic [WORD_W-1:0] pending_hashes[$];
    int unsigned       fails;

    function new();
      seed_word = '0;
      acc_hash  = '0;
      key_len   = '0;
      fails     = 0;
    endfunction

    function logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function logic [31:0] scramble(input logic [31:0] k);
      logic [31:0] t;
      t = k * K_MUL1;
      t = rotl(t, 15);
      t = t * K_MUL2;
      return t;
    endfunction

    function logic [31:0] avalanche(input logic [31:0] h);
      logic [31:0] t;
      t = h ^ (h >> 16);
      t = t * F_MUL1;
      t = t ^ (t >> 13);
      t = t * F_MUL2;
      t = t ^ (t >> 16);
      return t;
    endfunction

    // New seed takes effect at once only if the current key has no bytes yet
    function void load_seed(input logic [WORD_W-1:0] value);
      seed_word = value;
      if (key_len == '0) acc_hash = value;
    endfunction

    function void note_key_item(input logic [WORD_W-1:0] word,
                                input logic [NB_W-1:0] nb_raw, input logic eok);
      int unsigned nb;
      logic        closes;
      logic [31:0] h;
      logic [31:0] keep;
      nb     = (nb_raw > FULL_WORD) ? 4 : int'(nb_raw);
      closes = eok || (nb < 4);
      h      = acc_hash;
      if (nb == 4) begin
        h = h ^ scramble(word);
        h = rotl(h, 13) * H_MUL + H_ADD;
      end else if (nb > 0) begin
        keep = 32'hffff_ffff >> (8 * (4 - nb));
        h    = h ^ scramble(word & keep);
      end
      key_len = key_len + nb;
      if (!closes) begin
        acc_hash = h;
      end else begin
        pending_hashes.push_back(avalanche(h ^ key_len));
        acc_hash = seed_word;
        key_len  = '0;
      end
    endfunction

    function void check_hash(input logic [WORD_W-1:0] actual);
      logic [WORD_W-1:0] want;
      if (pending_hashes.size() == 0) begin
        $error("hash_value: no hash expected, actual %h", actual);
        fails++;
      end else begin
        want = pending_hashes.pop_front();
        if (actual !== want) begin
          $error("hash_value: expected %h, actual %h", want, actual);
          fails++;
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [WORD_W-1:0] cfg_wdata_i;

  m3h_key_if  key_if();
  m3h_hash_if hash_if();

  hash_scoreboard sb = new();

  int unsigned key_items_sent = 0;
  int unsigned burst_left     = 0;
  int unsigned cycle_count    = 0;
  bit          hold_off_req   = 1'b0;

  murmur3_32_hash_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .key_i      (key_if),
    .hash_o     (hash_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result checker: every accepted hash goes against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && hash_if.valid && hash_if.ready) sb.check_hash(hash_if.hash_value);
  end

  // ---------------------------------------------------------------------------
  // Receiver: changes its stall pattern at random points in time. On request
  // it holds off for a long stretch so the core backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : hash_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    mode          = SINK_ALWAYS;
    mode_left     = 0;
    hold_left     = 0;
    tick          = 0;
    hash_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        hash_if.ready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES - 1;
        hash_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          SINK_ALWAYS:   hash_if.ready <= 1'b1;
          SINK_BUSY:     hash_if.ready <= ($urandom_range(0, 99) < 70);
          SINK_SPARSE:   hash_if.ready <= ($urandom_range(0, 99) < 20);
          default:       hash_if.ready <= ((tick % 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. All are entered in the time step of a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one item; bursts of random length with random gaps in between.
  // Returns in the step of the accepting edge with valid still high.
  task automatic offer_item(input logic [WORD_W-1:0] word, input logic [NB_W-1:0] nb,
                            input logic eok);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        key_if.valid    <= 1'b0;
        key_if.key_word <= $urandom();   // junk while idle
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    key_if.valid      <= 1'b1;
    key_if.key_word   <= word;
    key_if.word_bytes <= nb;
    key_if.end_of_key <= eok;
    do @(posedge clk_i); while (key_if.ready !== 1'b1);
    sb.note_key_item(word, nb, eok);
    key_items_sent++;
  endtask

  // Stop sending, let every expected hash arrive, then let the core settle
  // (it may still be folding a word item that gives no hash).
  task automatic wait_for_hashes();
    key_if.valid <= 1'b0;
    while (sb.pending_hashes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [WORD_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.load_seed(value);
    cfg_we_i    <= 1'b0;
  endtask

  // One random key: mostly well-formed (full words then a closing item),
  // the rest odd byte counts, short words not marked last, or no closing
  // item at all so the key runs on into the next one.
  task automatic send_random_key();
    int unsigned shape;
    int unsigned words;
    int unsigned tail;
    logic [NB_W-1:0] nb;
    shape = $urandom_range(0, 99);
    if (shape < 70)      words = $urandom_range(0, 4);
    else if (shape < 92) words = $urandom_range(5, 16);
    else                 words = $urandom_range(17, 48);
    for (int unsigned i = 0; i < words; i++) begin
      nb = ($urandom_range(0, 9) == 0) ? NB_W'($urandom_range(5, 7)) : FULL_WORD;
      offer_item($urandom(), nb, 1'b0);
    end
    tail = $urandom_range(0, 99);
    if (tail < 78)      offer_item($urandom(), NB_W'($urandom_range(0, 4)), 1'b1);
    else if (tail < 86) offer_item($urandom(), NB_W'($urandom_range(5, 7)), 1'b1);
    else if (tail < 94) offer_item($urandom(), NB_W'($urandom_range(0, 3)), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [WORD_W-1:0] seed;
    int unsigned       target;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    key_if.valid      <= 1'b0;
    key_if.key_word   <= '0;
    key_if.word_bytes <= '0;
    key_if.end_of_key <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, seed 0 from reset.
    offer_item(32'hffff_ffff, 3'd0, 1'b1);    // empty key, junk in unused bytes
    offer_item(32'hdead_be80, 3'd1, 1'b1);    // one-byte tail, high bit set
    offer_item(32'h1234_8001, 3'd2, 1'b1);
    offer_item(32'ha5ff_ffff, 3'd3, 1'b1);
    offer_item(32'hffff_ffff, 3'd4, 1'b1);    // single full word, last
    offer_item(32'h0000_0000, 3'd4, 1'b0);
    offer_item(32'hffff_ffff, 3'd4, 1'b0);
    offer_item(32'h8765_4321, 3'd3, 1'b0);    // short word ends the key anyway
    offer_item(32'h5555_aaaa, 3'd7, 1'b0);    // count above four clamps to a full word
    offer_item(32'haaaa_5555, 3'd5, 1'b1);
    offer_item(32'h0102_0304, 3'd6, 1'b0);
    offer_item(32'hcafe_f00d, 3'd0, 1'b0);    // empty short word ends the key
    wait_for_hashes();

    write_seed(32'hffff_ffff);                // idle key: applies at once
    offer_item(32'h0000_0000, 3'd0, 1'b1);
    offer_item(32'h8000_0000, 3'd4, 1'b0);
    offer_item(32'h7fff_ffff, 3'd4, 1'b0);
    wait_for_hashes();
    write_seed(32'h8000_0000);                // mid-key: waits for the next key
    offer_item(32'h0000_ffff, 3'd2, 1'b1);
    offer_item(32'h0000_0001, 3'd4, 1'b1);
    offer_item(32'hffff_ffff, 3'd6, 1'b1);
    wait_for_hashes();

    // Random part in phases; each phase starts with a new seed. A phase may
    // end inside an open key, which exercises the deferred seed load.
    target = key_items_sent;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)                      seed = 32'h0000_0001;
      else if (p == 1)                 seed = 32'h0000_0000;
      else if (p == RANDOM_PHASES - 1) seed = 32'hffff_ffff;
      else                             seed = $urandom();
      write_seed(seed);
      if (p == 2) hold_off_req = 1'b1;        // sender keeps going meanwhile
      target += RANDOM_ITEMS / RANDOM_PHASES;
      while (key_items_sent < target) send_random_key();
      wait_for_hashes();
    end

    if (sb.fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
